[src/gf13au_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package gf13au_pkg;

    localparam int GF_W = 13;
    localparam int PROD_W = 2 * GF_W - 1;
    localparam int CHAIN_DEPTH = 12;

    typedef logic [GF_W-1:0]   t_elem;
    typedef logic [PROD_W-1:0] t_prod;
    typedef logic [2:0]        t_mode;

    localparam t_mode MODE_MUL    = 3'd0;
    localparam t_mode MODE_SQR    = 3'd1;
    localparam t_mode MODE_DIV    = 3'd2;
    localparam t_mode MODE_INV    = 3'd3;
    localparam t_mode MODE_PREINV = 3'd4;
    localparam t_mode MODE_ZERO   = 3'd5;

    localparam t_elem GF_ONE  = 13'h0001;
    localparam t_elem GF_ZERO = 13'h0000;
    localparam t_elem GF_ALL  = 13'h1FFF;

    typedef struct packed {
        t_mode mode;
        t_elem a;
        t_elem b;
        t_elem r;
    } t_item;

    // carry-less product, independent partial products
    function automatic t_prod gf_clmul(input t_elem x, input t_elem y);
        t_prod p;
        p = '0;
        for (int i = 0; i < GF_W; i++) begin
            if (y[i]) begin
                p = p ^ (t_prod'(x) << i);
            end
        end
        return p;
    endfunction

    // two-fold reduction by x^13 + x^4 + x^3 + x + 1
    function automatic t_elem gf_reduce(input t_prod p);
        logic [11:0] h;
        logic [15:0] f;
        logic [2:0]  g;
        logic [6:0]  e;
        h = p[PROD_W-1:GF_W];
        f = {4'd0, h} ^ ({4'd0, h} << 1) ^ ({4'd0, h} << 3) ^ ({4'd0, h} << 4);
        g = f[15:13];
        e = {4'd0, g} ^ ({4'd0, g} << 1) ^ ({4'd0, g} << 3) ^ ({4'd0, g} << 4);
        return p[GF_W-1:0] ^ f[GF_W-1:0] ^ {6'd0, e};
    endfunction

    function automatic t_elem gf_mul(input t_elem x, input t_elem y);
        return gf_reduce(gf_clmul(x, y));
    endfunction

    // squaring is linear: spread the bits, then reduce
    function automatic t_elem gf_sq(input t_elem x);
        t_prod s;
        s = '0;
        for (int i = 0; i < GF_W; i++) begin
            s[2*i] = x[i];
        end
        return gf_reduce(s);
    endfunction

endpackage

`default_nettype wire

[src/gf2_13_arithmetic_unit_top.sv]
`timescale 1ns / 1ps
`default_nettype none

// GF(2^13) arithmetic unit, polynomial x^13+x^4+x^3+x+1. Modes: multiply,
// square, divide (b/a), inverse, pre-inverse a^(2^12-1) and zero test.
// Zero has inverse 0 and b/0 gives 0. One operation is taken per cycle
// while o_ready is high. Twelve square-multiply stages compute a^(2^12-1).
// A final stage squares, multiplies and selects the result into the output
// register. Each stage stalls only when it holds an item that the next
// stage cannot take, so bubbles collapse under back-pressure.

module gf2_13_arithmetic_unit_top (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_valid,
    output logic        o_ready,
    input  wire  [2:0]  i_mode,
    input  wire  [12:0] i_operand_a,
    input  wire  [12:0] i_operand_b,
    output logic        o_valid,
    input  wire         i_ready,
    output logic [12:0] o_result
);
    import gf13au_pkg::*;

    logic  w_valid [CHAIN_DEPTH+1];
    logic  w_ready [CHAIN_DEPTH+1];
    t_item w_item  [CHAIN_DEPTH+1];

    assign w_valid[0]  = i_valid;
    assign o_ready     = w_ready[0];
    assign w_item[0].mode = i_mode;
    assign w_item[0].a    = i_operand_a;
    assign w_item[0].b    = i_operand_b;
    assign w_item[0].r    = GF_ONE;

    for (genvar k = 0; k < CHAIN_DEPTH; k++) begin : g_chain
        gf13au_stage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[k]),
            .o_ready (w_ready[k]),
            .i_item  (w_item[k]),
            .o_valid (w_valid[k+1]),
            .i_ready (w_ready[k+1]),
            .o_item  (w_item[k+1])
        );
    end

    logic  r_valid;
    t_elem r_result;
    t_elem n_result;
    t_item w_last;
    t_elem w_sq_r;
    t_elem w_mul_x;
    t_elem w_prod;
    logic  w_adv;

    assign w_last  = w_item[CHAIN_DEPTH];
    assign w_adv   = !r_valid || i_ready;
    assign w_ready[CHAIN_DEPTH] = w_adv;

    assign w_sq_r  = gf_sq(w_last.r);
    assign w_mul_x = (w_last.mode == MODE_MUL) ? w_last.a : w_sq_r;
    assign w_prod  = gf_mul(w_mul_x, w_last.b);

    always_comb begin
        unique case (w_last.mode)
            MODE_MUL,
            MODE_DIV:    n_result = w_prod;
            MODE_SQR:    n_result = gf_sq(w_last.a);
            MODE_INV:    n_result = w_sq_r;
            MODE_PREINV: n_result = w_last.r;
            MODE_ZERO:   n_result = (w_last.a == GF_ZERO) ? GF_ALL : GF_ZERO;
            default:     n_result = GF_ZERO;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_adv) begin
            r_valid <= w_valid[CHAIN_DEPTH];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && w_valid[CHAIN_DEPTH]) begin
            r_result <= n_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

`default_nettype wire

[src/gf13au_stage.sv]
`timescale 1ns / 1ps
`default_nettype none

module gf13au_stage (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    output logic                o_ready,
    input  gf13au_pkg::t_item   i_item,
    output logic                o_valid,
    input  wire                 i_ready,
    output gf13au_pkg::t_item   o_item
);
    import gf13au_pkg::*;

    logic  r_valid;
    t_item r_item;
    t_item n_item;
    logic  w_adv;

    assign w_adv   = !r_valid || i_ready;
    assign o_ready = w_adv;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_comb begin
        n_item   = i_item;
        n_item.r = gf_mul(gf_sq(i_item.r), i_item.a);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && i_valid) begin
            r_item <= n_item;
        end
    end

endmodule

`default_nettype wire

[test/gf13_result_checker.sv]
`timescale 1ns / 1ps

module gf13_result_checker (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_in_valid,
    input  wire         i_in_ready,
    input  wire  [2:0]  i_mode,
    input  wire  [12:0] i_operand_a,
    input  wire  [12:0] i_operand_b,
    input  wire         i_out_valid,
    input  wire         i_out_ready,
    input  wire  [12:0] i_result,
    output int          o_fail_count,
    output int          o_pending
);
    import gf13au_pkg::*;

    localparam logic [GF_W:0] FIELD_POLY = 14'h201B;

    t_item awaited_results[$];

    // shift-and-add product, reduced one bit at a time
    function automatic t_elem field_mul(input t_elem x, input t_elem y);
        logic [GF_W:0] acc;
        acc = '0;
        for (int i = GF_W - 1; i >= 0; i--) begin
            acc = acc << 1;
            if (acc[GF_W]) begin
                acc = acc ^ FIELD_POLY;
            end
            if (y[i]) begin
                acc = acc ^ {1'b0, x};
            end
        end
        return acc[GF_W-1:0];
    endfunction

    // x^(2^12-1) by twelve square-and-multiply steps
    function automatic t_elem field_pre_inverse(input t_elem x);
        t_elem acc;
        acc = GF_ONE;
        for (int i = 0; i < 12; i++) begin
            acc = field_mul(field_mul(acc, acc), x);
        end
        return acc;
    endfunction

    function automatic t_elem field_result(input t_mode m, input t_elem a, input t_elem b);
        t_elem pre;
        pre = field_pre_inverse(a);
        case (m)
            MODE_MUL:    return field_mul(a, b);
            MODE_SQR:    return field_mul(a, a);
            MODE_DIV:    return field_mul(field_mul(pre, pre), b);
            MODE_INV:    return field_mul(pre, pre);
            MODE_PREINV: return pre;
            MODE_ZERO:   return (a == GF_ZERO) ? GF_ALL : GF_ZERO;
            default:     return GF_ZERO;
        endcase
    endfunction

    always @(posedge i_clk) begin
        t_item head;
        t_item op;
        if (!i_rst_n) begin
            o_fail_count <= 0;
            o_pending    <= 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (awaited_results.size() == 0) begin
                    if (o_fail_count < 10) begin
                        $display("ERROR: result %h with no operation outstanding", i_result);
                    end
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    head = awaited_results.pop_front();
                    if (head.r !== i_result) begin
                        if (o_fail_count < 10) begin
                            $display("ERROR: mode %0d a %h b %h: expected %h, got %h",
                                     head.mode, head.a, head.b, head.r, i_result);
                        end
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                op.mode = i_mode;
                op.a    = i_operand_a;
                op.b    = i_operand_b;
                op.r    = field_result(i_mode, i_operand_a, i_operand_b);
                awaited_results.push_back(op);
            end
            o_pending <= awaited_results.size();
        end
    end

endmodule

[test/gf2_13_arithmetic_unit_top_test.sv]
`timescale 1ns / 1ps

module gf2_13_arithmetic_unit_top_test;
    import gf13au_pkg::*;

    localparam int RANDOM_OPS   = 1800;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLD_FROM    = 600;
    localparam int HOLD_TO      = 900;
    localparam int CALM_FROM    = 1500;
    localparam int CALM_TO      = 2000;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_valid     = 1'b0;
    logic [2:0]  i_mode      = '0;
    logic [12:0] i_operand_a = '0;
    logic [12:0] i_operand_b = '0;
    logic        i_ready     = 1'b0;
    logic        o_ready;
    logic        o_valid;
    logic [12:0] o_result;

    int fail_count;
    int pending;
    int cycle_count = 0;
    int rx_cycles   = 0;
    logic calm;

    assign calm = (cycle_count >= CALM_FROM) && (cycle_count < CALM_TO);

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    gf2_13_arithmetic_unit_top u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_mode      (i_mode),
        .i_operand_a (i_operand_a),
        .i_operand_b (i_operand_b),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_result    (o_result)
    );

    gf13_result_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_valid),
        .i_in_ready   (o_ready),
        .i_mode       (i_mode),
        .i_operand_a  (i_operand_a),
        .i_operand_b  (i_operand_b),
        .i_out_valid  (o_valid),
        .i_out_ready  (i_ready),
        .i_result     (o_result),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // receiver: random stalls, one long hold-off to back the pipeline up, and a calm window that is always ready
    always @(posedge i_clk) begin
        rx_cycles <= rx_cycles + 1;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (rx_cycles >= HOLD_FROM && rx_cycles < HOLD_TO) begin
            i_ready <= 1'b0;
        end else if (calm) begin
            i_ready <= 1'b1;
        end else begin
            i_ready <= ($urandom_range(99) >= 16);
        end
    end

    task automatic offer_op(input t_mode m, input t_elem a, input t_elem b);
        i_valid     <= 1'b1;
        i_mode      <= m;
        i_operand_a <= a;
        i_operand_b <= b;
        @(posedge i_clk);
        while (!o_ready) begin
            @(posedge i_clk);
        end
    endtask

    task automatic sender_gap();
        while (!calm && $urandom_range(99) < 16) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    function automatic t_elem pick_elem();
        case ($urandom_range(9))
            0:       return GF_ZERO;
            1:       return GF_ONE;
            2:       return GF_ALL;
            default: return t_elem'($urandom);
        endcase
    endfunction

    initial begin
        t_mode m;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int k = 0; k <= MODE_ZERO; k++) begin
            m = t_mode'(k);
            offer_op(m, GF_ZERO, GF_ALL);
            offer_op(m, GF_ONE, GF_ONE);
            offer_op(m, GF_ALL, GF_ALL);
            offer_op(m, 13'h1000, 13'h0002);
        end

        for (int n = 0; n < RANDOM_OPS; n++) begin
            sender_gap();
            offer_op(t_mode'($urandom_range(MODE_ZERO)), pick_elem(), pick_elem());
        end
        i_valid <= 1'b0;
        @(posedge i_clk);

        while (pending != 0) begin
            @(posedge i_clk);
        end
        repeat (30) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
